FILE: sv/assert_macros.svh
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and round functions for the AES-128 pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

   // Configuration register indexes.
   localparam logic [0:0] CSR_KEY_HIGH = 1'b0;
   localparam logic [0:0] CSR_KEY_LOW  = 1'b1;
   localparam int         CSR_IDX_W    = 1;

   localparam int         NUM_ROUNDS   = 10;
   localparam logic [7:0] GF_POLY      = 8'h1B;
   localparam logic [7:0] GF_TOP       = 8'h80;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_item_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_item_type;

   // Forward S-box.
   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
   endfunction

   // Multiply by x in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] v);
      logic [7:0] s;
      s = {v[6:0], 1'b0};
      return ((v & GF_TOP) != 8'h00) ? (s ^ GF_POLY) : s;
   endfunction

   // Byte b of a 128-bit state, byte 0 in the top bits.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int b);
      return s[127 - 8*b -: 8];
   endfunction

   // SubBytes and ShiftRows, then MixColumns when mix is set.
   function automatic logic [127:0] round_data(input logic [127:0] s, input logic mix);
      logic [7:0]   t [16];
      logic [127:0] r;
      logic [7:0]   a0, a1, a2, a3, all;
      for (int k = 0; k < 16; k++) begin
         t[k] = sbox(get_byte(s, (k + 4*(k % 4)) % 16));
      end
      for (int c = 0; c < 16; c += 4) begin
         a0 = t[c]; a1 = t[c+1]; a2 = t[c+2]; a3 = t[c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (mix) begin
            t[c]   = a0 ^ all ^ xtime(a0 ^ a1);
            t[c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            t[c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            t[c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int k = 0; k < 16; k++) begin
         r[127 - 8*k -: 8] = t[k];
      end
      return r;
   endfunction

   // One step of the key schedule.
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

`default_nettype wire

FILE: sv/aes128_round.sv
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered pipeline stage: a full or final round plus key expansion.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aes128_round
   import aes128_pkg::*;
#(
   parameter logic [7:0] RCON  = 8'h01,
   parameter bit         FINAL = 1'b0
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire logic [127:0]   in_state,
   input  wire logic [127:0]   in_key,
   output logic                out_valid,
   output logic [127:0]        out_state,
   output logic [127:0]        out_key
);

   logic [127:0] key_in;
   logic [127:0] state_in;
   logic         valid_ff;
   logic [127:0] state_ff;
   logic [127:0] key_ff;

   // Round key and round data for this stage.
   always_comb begin
      key_in   = next_key(in_key, RCON);
      state_in = round_data(in_state, !FINAL) ^ key_in;
   end

   // Valid bit is control state; data registers take no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      key_ff   <= key_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_key   = key_ff;

   `ASSERT_CLK(a_valid_follows, clock, reset, in_valid |=> out_valid, "stage lost an item")
   `ASSERT_CLK(a_no_spurious, clock, reset, !in_valid |=> !out_valid, "stage invented an item")

endmodule

`default_nettype wire

FILE: sv/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Fully pipelined AES-128 encryption with a configurable cipher key.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through the csr_ port: index 0 is key bytes 0..7, index 1
//   is bytes 8..15. Writes take effect at once; change the key only while
//   no item is in flight. Other indexes are ignored.
//   Raise start with a plaintext item on req_item; it is taken whenever busy
//   is low, and busy is always low, so an item can enter every cycle.
//   Each ciphertext item appears on rsp_item for one cycle with rsp_valid.
// Pipeline: an input register with the initial key add, then ten round
//   stages, one per round, each with its own key expansion step.
// Throughput: one item per cycle.
// Reset clears the key to zero and drops all items in flight.
// The receiver cannot stall; results are offered exactly once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aes128_block_encrypt
   import aes128_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_item_type         req_item,
   output logic                      rsp_valid,
   output rsp_item_type              rsp_item,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_wdata
);

   localparam logic [7:0] RCON_TAB [NUM_ROUNDS] = '{8'h01, 8'h02, 8'h04, 8'h08,
      8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   logic [63:0]  key_high_ff;
   logic [63:0]  key_low_ff;
   logic         valid_ff;
   logic [127:0] state_ff;
   logic [127:0] key_ff;

   logic         stg_valid [NUM_ROUNDS+1];
   logic [127:0] stg_state [NUM_ROUNDS+1];
   logic [127:0] stg_key   [NUM_ROUNDS+1];

   assign busy = 1'b0;

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage with the initial key add.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= {req_item.block_high, req_item.block_low} ^ {key_high_ff, key_low_ff};
      key_ff   <= {key_high_ff, key_low_ff};
   end

   assign stg_valid[0] = valid_ff;
   assign stg_state[0] = state_ff;
   assign stg_key[0]   = key_ff;

   // Ten round stages.
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      aes128_round #(
         .RCON  (RCON_TAB[r]),
         .FINAL (r == NUM_ROUNDS - 1)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[r]),
         .in_state  (stg_state[r]),
         .in_key    (stg_key[r]),
         .out_valid (stg_valid[r+1]),
         .out_state (stg_state[r+1]),
         .out_key   (stg_key[r+1])
      );
   end

   assign rsp_valid            = stg_valid[NUM_ROUNDS];
   assign rsp_item.cipher_high = stg_state[NUM_ROUNDS][127:64];
   assign rsp_item.cipher_low  = stg_state[NUM_ROUNDS][63:0];

   `ASSERT_ALWAYS(a_never_busy, clock, !busy, "busy raised")
   `ASSERT_CLK(a_latency, clock, reset, start && !busy |-> ##11 rsp_valid, "result missing")
   `ASSERT_CLK(a_key_stable, clock, reset, !csr_we |=> $stable(key_high_ff) && $stable(key_low_ff), "key changed without a write")

endmodule

`default_nettype wire
